FILE: hw/rtl/sird_pkg.sv
// Package for the signed integer to radix digits block: widths, types and the state encoding.
`timescale 1ns / 1ps
package sird_pkg;

    localparam int VALUE_W        = 32;
    localparam int RADIX_W        = 9;
    localparam int DIGIT_W        = 8;
    localparam int RADIX_RESET    = 10;
    localparam int MIN_RADIX      = 2;
    localparam int DEF_MAX_RADIX  = 256;
    localparam int DEF_MAX_DIGITS = 32;
    localparam int BITS_PER_CYC   = 4;
    localparam int DIV_STEPS      = VALUE_W / BITS_PER_CYC;
    localparam int STEP_W         = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ERR,
        S_DIV,
        S_WR,
        S_RD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic div_en;
        logic wr_en;
        logic rd_first;
        logic rd_next;
        logic emit_err;
        logic emit_digit;
    } t_cmd;

    typedef struct packed {
        logic base_bad;
        logic step_last;
        logic digits_done;
        logic idx_zero;
    } t_status;

endpackage

FILE: hw/rtl/sird_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sird_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/sird_ctrl.sv
// Controller FSM: sequences accept, bad-radix error, divide, digit write and read-out.
`timescale 1ns / 1ps
module sird_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  sird_pkg::t_status i_status,
    output sird_pkg::t_cmd    o_cmd,
    output logic              o_busy
);

    import sird_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = i_status.base_bad ? S_ERR : S_DIV;
                end
            end
            S_ERR: n_state = S_IDLE;
            S_DIV: begin
                if (i_status.step_last) begin
                    n_state = S_WR;
                end
            end
            S_WR: n_state = i_status.digits_done ? S_RD : S_DIV;
            S_RD: n_state = S_OUT;
            S_OUT: begin
                if (i_status.idx_zero) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_busy           = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_busy       = 1'b0;
                o_cmd.accept = i_start;
            end
            S_ERR:   o_cmd.emit_err = 1'b1;
            S_DIV:   o_cmd.div_en   = 1'b1;
            S_WR:    o_cmd.wr_en    = 1'b1;
            S_RD:    o_cmd.rd_first = 1'b1;
            S_OUT: begin
                o_cmd.emit_digit = 1'b1;
                o_cmd.rd_next    = 1'b1;
            end
            default: o_busy = 1'b0;
        endcase
    end

`ifndef SYNTH
    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ERR |=> r_state == S_IDLE)
        else $error("error result not followed by idle");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && i_status.idx_zero) |=> r_state == S_IDLE)
        else $error("digits emitted after last");
    a_bad_goes_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start && i_status.base_bad) |=> r_state == S_ERR)
        else $error("bad radix item did not take error path");
`endif

endmodule

FILE: hw/rtl/sird_dp.sv
// Datapath: radix register, 4-bit-per-cycle restoring divider, digit store and result ports.
`timescale 1ns / 1ps
module sird_dp #(
    parameter int MAX_RADIX  = sird_pkg::DEF_MAX_RADIX,
    parameter int MAX_DIGITS = sird_pkg::DEF_MAX_DIGITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sird_pkg::RADIX_W-1:0]        i_cfg_data,
    input  logic signed [sird_pkg::VALUE_W-1:0] i_value,
    input  sird_pkg::t_cmd                      i_cmd,
    output sird_pkg::t_status                   o_status,
    output logic                                o_strobe,
    output logic [sird_pkg::DIGIT_W-1:0]        o_digit,
    output logic                                o_negative,
    output logic                                o_bad_radix,
    output logic                                o_last
);

    import sird_pkg::*;

    localparam int AW = $clog2(MAX_DIGITS);
    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int CAP_I = (MAX_RADIX < (1 << RADIX_W)) ? MAX_RADIX : (1 << RADIX_W) - 1;
    localparam logic [RADIX_W-1:0] BASE_CAP = RADIX_W'(CAP_I);

    logic [RADIX_W-1:0] r_radix;
    logic [RADIX_W-1:0] r_base;
    logic [RADIX_W-1:0] r_rem;
    logic [VALUE_W-1:0] r_q;
    logic [STEP_W-1:0]  r_step;
    logic [CW-1:0]      r_cnt;
    logic [AW-1:0]      r_idx;
    logic               r_neg;

    logic [RADIX_W-1:0] n_rem;
    logic [VALUE_W-1:0] n_q;
    logic [RADIX_W:0]   w_try;
    logic [RADIX_W-1:0] w_base;
    logic [VALUE_W-1:0] w_raw;
    logic [VALUE_W-1:0] w_mag;
    logic [CW-1:0]      w_cnt_m1;
    logic [AW-1:0]      w_raddr;
    logic [DIGIT_W-1:0] w_rdata;

    assign w_base = (r_radix > BASE_CAP) ? BASE_CAP : r_radix;
    assign w_raw  = i_value;
    assign w_mag  = w_raw[VALUE_W-1] ? (~w_raw + 1'b1) : w_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_W'(RADIX_RESET);
        end else if (i_cfg_we) begin
            r_radix <= i_cfg_data;
        end
    end

    always_comb begin
        n_rem = r_rem;
        n_q   = r_q;
        w_try = '0;
        for (int i = 0; i < BITS_PER_CYC; i++) begin
            w_try = {n_rem, n_q[VALUE_W-1]};
            n_q   = {n_q[VALUE_W-2:0], 1'b0};
            if (w_try >= {1'b0, r_base}) begin
                w_try  = w_try - {1'b0, r_base};
                n_q[0] = 1'b1;
            end
            n_rem = w_try[RADIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_step <= '0;
            r_idx  <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_cnt  <= '0;
                r_step <= '0;
            end
            if (i_cmd.div_en) begin
                r_step <= o_status.step_last ? '0 : r_step + 1'b1;
            end
            if (i_cmd.wr_en) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.rd_first || i_cmd.rd_next) begin
                r_idx <= w_raddr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_neg  <= w_raw[VALUE_W-1];
            r_base <= w_base;
            r_q    <= w_mag;
            r_rem  <= '0;
        end
        if (i_cmd.div_en) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
        if (i_cmd.wr_en) begin
            r_rem <= '0;
        end
    end

    assign w_cnt_m1 = r_cnt - 1'b1;
    assign w_raddr  = i_cmd.rd_first ? w_cnt_m1[AW-1:0] : r_idx - 1'b1;

    sird_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (MAX_DIGITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (r_rem[DIGIT_W-1:0]),
        .i_re    (i_cmd.rd_first || i_cmd.rd_next),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_status.base_bad    = r_radix < RADIX_W'(MIN_RADIX);
    assign o_status.step_last   = r_step == STEP_W'(DIV_STEPS - 1);
    assign o_status.digits_done = (r_q == '0) || (r_cnt == CW'(MAX_DIGITS - 1));
    assign o_status.idx_zero    = r_idx == '0;

    assign o_strobe    = i_cmd.emit_err || i_cmd.emit_digit;
    assign o_digit     = i_cmd.emit_digit ? w_rdata : '0;
    assign o_negative  = r_neg;
    assign o_bad_radix = i_cmd.emit_err;
    assign o_last      = i_cmd.emit_err || (i_cmd.emit_digit && o_status.idx_zero);

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_en |-> r_cnt < CW'(MAX_DIGITS))
        else $error("digit store overrun");
    a_rem_below_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.div_en || i_cmd.wr_en) |-> r_rem < r_base)
        else $error("remainder not below base");
    a_accept_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept |=> (r_cnt == '0 && r_step == '0))
        else $error("count not cleared on accept");
`endif

endmodule

FILE: hw/rtl/signed_integer_to_radix_digits.sv
// Top level: signed integer to radix digits converter, controller plus datapath.
//
// Channel  Direction  Handshake                    Payload
// cfg      in         i_cfg_valid / o_cfg_ready    i_cfg_data (radix)
// cmd      in         start & !busy                i_value
// result   out        o_strobe, one cycle          o_digit o_negative o_bad_radix o_last
//
// Bad radix: result in the cycle after the item is taken, busy only while it shows.
// Otherwise each digit comes from the divider (4 quotient bits a cycle, then
// a digit store write); after a read setup state, one digit goes out per cycle.
// Synchronous reset sets radix to 10 and the controller idle.
// Results cannot be stalled; cfg is ready only while idle.
`timescale 1ns / 1ps
module signed_integer_to_radix_digits #(
    parameter int MAX_RADIX  = sird_pkg::DEF_MAX_RADIX,
    parameter int MAX_DIGITS = sird_pkg::DEF_MAX_DIGITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sird_pkg::RADIX_W-1:0]        i_cfg_data,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [sird_pkg::VALUE_W-1:0] i_value,
    output logic                                o_strobe,
    output logic [sird_pkg::DIGIT_W-1:0]        o_digit,
    output logic                                o_negative,
    output logic                                o_bad_radix,
    output logic                                o_last
);

    import sird_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    assign o_cfg_ready = !busy;

    sird_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy)
    );

    sird_dp #(
        .MAX_RADIX  (MAX_RADIX),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_value     (i_value),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_strobe    (o_strobe),
        .o_digit     (o_digit),
        .o_negative  (o_negative),
        .o_bad_radix (o_bad_radix),
        .o_last      (o_last)
    );

endmodule

FILE: test/tb_signed_integer_to_radix_digits.sv
// Testbench for signed_integer_to_radix_digits: directed and random conversions checked per digit.
`timescale 1ns / 1ps

typedef struct packed {
    logic [sird_pkg::DIGIT_W-1:0] digit;
    logic                         negative;
    logic                         bad_radix;
    logic                         last;
} t_digit_result;

class digit_scoreboard;
    logic [sird_pkg::RADIX_W-1:0] radix;
    t_digit_result                expected_digits[$];
    int                           mismatches;
    int                           values_seen;
    int                           digits_seen;
    int                           bad_radix_seen;
    int                           longest_number;

    function new();
        radix = sird_pkg::RADIX_RESET;
    endfunction

    function int pending();
        return expected_digits.size();
    endfunction

    // Predict the digit results of one accepted item.
    function void note_value(logic [sird_pkg::VALUE_W-1:0] value);
        logic [31:0]                  magnitude;
        logic [31:0]                  base;
        logic [sird_pkg::DIGIT_W-1:0] msd_first[$];
        logic                         neg;
        neg = value[31];
        values_seen++;
        if (radix < sird_pkg::MIN_RADIX) begin
            expected_digits.push_back('{digit: '0, negative: neg, bad_radix: 1'b1, last: 1'b1});
            return;
        end
        base = (radix > sird_pkg::DEF_MAX_RADIX) ? sird_pkg::DEF_MAX_RADIX : radix;
        magnitude = neg ? (~value + 32'd1) : value;
        do begin
            msd_first.push_front(8'(magnitude % base));
            magnitude = magnitude / base;
        end while (magnitude != 0 && msd_first.size() < sird_pkg::DEF_MAX_DIGITS);
        if (msd_first.size() > longest_number) longest_number = msd_first.size();
        foreach (msd_first[k])
            expected_digits.push_back('{digit: msd_first[k], negative: neg, bad_radix: 1'b0,
                                        last: (k == msd_first.size() - 1)});
    endfunction

    function void check_result(t_digit_result got);
        t_digit_result want;
        if (expected_digits.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected digit %0d neg %b bad %b last %b", $time,
                         got.digit, got.negative, got.bad_radix, got.last);
            return;
        end
        want = expected_digits.pop_front();
        digits_seen++;
        if (got.bad_radix === 1'b1) bad_radix_seen++;
        if (got.digit !== want.digit || got.negative !== want.negative ||
            got.bad_radix !== want.bad_radix || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"%0t: digit exp %0d got %0d, neg exp %b got %b, ",
                          "bad exp %b got %b, last exp %b got %b"},
                         $time, want.digit, got.digit, want.negative, got.negative,
                         want.bad_radix, got.bad_radix, want.last, got.last);
        end
    endfunction
endclass

module tb_signed_integer_to_radix_digits;
    import sird_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [RADIX_W-1:0]   i_cfg_data  = '0;
    logic                 start       = 1'b0;
    logic                 busy;
    logic signed [VALUE_W-1:0] i_value = '0;
    logic                 o_strobe;
    logic [DIGIT_W-1:0]   o_digit;
    logic                 o_negative;
    logic                 o_bad_radix;
    logic                 o_last;

    digit_scoreboard sb = new();
    bit              idle_on = 1'b1;
    int              radix_writes;
    int              cycles;
    int              leftover;
    int              radix_plan[14] = '{10, 2, 3, 7, 16, 36, 255, 256, 257, 511, 0, 1, 0, 0};

    signed_integer_to_radix_digits DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .start       (start),
        .busy        (busy),
        .i_value     (i_value),
        .o_strobe    (o_strobe),
        .o_digit     (o_digit),
        .o_negative  (o_negative),
        .o_bad_radix (o_bad_radix),
        .o_last      (o_last)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            sb.check_result({o_digit, o_negative, o_bad_radix, o_last});
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("signed_integer_to_radix_digits verification failed");
            $finish;
        end
    end

    task automatic send_value(input logic [VALUE_W-1:0] v);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (busy);
        sb.note_value(v);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_radix(input logic [RADIX_W-1:0] r);
        repeat ($urandom_range(0, 4)) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= r;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.radix = r;
        radix_writes++;
    endtask

    // Mix of full-range, small, extreme and near-power-of-base values.
    function automatic logic [VALUE_W-1:0] random_value();
        longint b;
        longint p;
        logic [VALUE_W-1:0] v;
        b = sb.radix;
        if (b < MIN_RADIX) b = 10;
        if (b > DEF_MAX_RADIX) b = DEF_MAX_RADIX;
        case ($urandom_range(0, 6))
            0: v = $urandom;
            1: v = $urandom_range(0, 1000);
            2: v = 32'd0 - 32'($urandom_range(1, 1000));
            3: v = $urandom >> $urandom_range(0, 31);
            4: v = $urandom | 32'h8000_0000;
            5: begin
                p = 1;
                repeat ($urandom_range(1, 31)) if (p * b <= 64'h8000_0000) p = p * b;
                v = 32'(p - $urandom_range(0, 1));
                if ($urandom_range(0, 1)) v = ~v + 32'd1;
            end
            default: begin
                case ($urandom_range(0, 4))
                    0: v = 32'h0000_0000;
                    1: v = 32'hFFFF_FFFF;
                    2: v = 32'h7FFF_FFFF;
                    3: v = 32'h8000_0000;
                    default: v = 32'h8000_0001;
                endcase
            end
        endcase
        return v;
    endfunction

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset radix of ten
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'hFFFF_FFFF);
        send_value(32'd9);
        send_value(32'd10);
        send_value(32'hFFFF_FFF6);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        drain();
        // base two: longest numbers
        write_radix(9'd2);
        send_value(32'h8000_0000);
        send_value(32'h7FFF_FFFF);
        send_value(32'd1);
        drain();
        write_radix(9'd256);
        send_value(32'd255);
        send_value(32'd256);
        send_value(32'hFFFF_FF00);
        send_value(32'h8000_0000);
        drain();
        // bad radix
        write_radix(9'd0);
        send_value(32'd5);
        send_value(32'hFFFF_FFFB);
        send_value(32'd0);
        drain();
        write_radix(9'd1);
        send_value(32'h8000_0000);
        drain();
        // saturates to 256
        write_radix(9'd300);
        send_value(32'h1234_5678);
        drain();
        write_radix(9'd511);
        send_value(32'h7FFF_FFFF);
        drain();

        radix_plan[12] = $urandom_range(2, 256);
        radix_plan[13] = $urandom_range(0, 511);
        foreach (radix_plan[i]) begin
            idle_on = ($urandom_range(0, 3) != 0);
            write_radix(radix_plan[i][RADIX_W-1:0]);
            repeat (18) send_value(random_value());
            drain();
        end

        repeat (40) @(posedge i_clk);
        leftover = sb.pending();
        $display("%0d conversions over %0d radix writes, bases 0 to 511 incl. bad and saturated",
                 sb.values_seen, radix_writes);
        $display("%0d digits checked, %0d bad-radix results, longest number %0d digits",
                 sb.digits_seen, sb.bad_radix_seen, sb.longest_number);
        if (leftover != 0)
            $display("%0d expected digits never arrived", leftover);
        if (sb.mismatches == 0 && leftover == 0) begin
            $display("signed_integer_to_radix_digits verification clean");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("signed_integer_to_radix_digits verification failed");
        end
        $finish;
    end

endmodule
